@@ src/gsm7_septet_unpacker_core_macros.svh @@
`ifndef GSM7_SEPTET_UNPACKER_CORE_MACROS_SVH
`define GSM7_SEPTET_UNPACKER_CORE_MACROS_SVH

// checked on every edge outside reset
`define GSM7_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define GSM7_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/gsm7_pkg.sv @@
package gsm7_pkg;

  localparam int OCTET_W    = 8;
  localparam int SEPTET_W   = 7;
  localparam int COUNT_W    = 8;
  localparam int PHASE_W    = 3;
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_CNT_W = 2;

  localparam logic [PHASE_W-1:0] GROUP_LAST = 3'd6;

  typedef enum logic [0:0] {
    REG_PAD_FIRST    = 1'b0,
    REG_SEPTET_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [OCTET_W-1:0] held_octet;
    logic [PHASE_W-1:0] bit_phase;
    logic [COUNT_W-1:0] emitted_count;
    logic               first_done;
  } unpk_state_t;

  localparam unpk_state_t STATE_RESET = '{
    held_octet:    '0,
    bit_phase:     '0,
    emitted_count: '0,
    first_done:    1'b0
  };

  typedef struct packed {
    logic [SEPTET_W-1:0] character;
    logic                final_char;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  localparam logic [SEPTET_W-1:0] GSM_TO_ASCII [128] = '{
    7'h40, 7'h20, 7'h24, 7'h20, 7'h65, 7'h65, 7'h75, 7'h69,
    7'h6F, 7'h43, 7'h0A, 7'h30, 7'h30, 7'h20, 7'h41, 7'h61,
    7'h20, 7'h5F, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20,
    7'h20, 7'h20, 7'h20, 7'h1B, 7'h41, 7'h61, 7'h42, 7'h45,
    7'h20, 7'h21, 7'h22, 7'h23, 7'h20, 7'h25, 7'h26, 7'h27,
    7'h28, 7'h29, 7'h2A, 7'h2B, 7'h2C, 7'h2D, 7'h2E, 7'h2F,
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h3A, 7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F,
    7'h21, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
    7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F,
    7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
    7'h58, 7'h59, 7'h5A, 7'h41, 7'h4F, 7'h4E, 7'h55, 7'h20,
    7'h3F, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h69, 7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F,
    7'h70, 7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77,
    7'h78, 7'h79, 7'h7A, 7'h61, 7'h6F, 7'h6E, 7'h75, 7'h61
  };

endpackage

@@ src/gsm7_octet_if.sv @@
interface gsm7_octet_if import gsm7_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OCTET_W-1:0] octet;

  modport source (output valid, output octet, input ready);
  modport sink (input valid, input octet, output ready);
endinterface

@@ src/gsm7_char_if.sv @@
interface gsm7_char_if import gsm7_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SEPTET_W-1:0] character;
  logic                final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink (input valid, input character, input final_char, output ready);
endinterface

@@ src/gsm7_cfg_if.sv @@
interface gsm7_cfg_if import gsm7_pkg::*;;
  logic               valid;
  logic               ready;
  cfg_reg_e           index;
  logic [COUNT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/gsm7_unpack.sv @@
module gsm7_unpack import gsm7_pkg::*; (
  input  logic [OCTET_W-1:0] octet,
  input  unpk_state_t        st,
  input  logic               pad_first,
  input  logic [COUNT_W-1:0] septet_count,
  output unpk_state_t        st_next,
  output push_t              push
);

  logic [2*OCTET_W-1:0] window;
  logic [3:0]           shamt;
  logic [SEPTET_W-1:0]  sept0;
  logic [SEPTET_W-1:0]  upper;
  logic [COUNT_W:0]     plus1;
  logic [COUNT_W:0]     plus2;
  logic                 active;
  logic                 room1;

  always_comb begin
    shamt  = 4'd8 - {1'b0, st.bit_phase};
    window = {octet, st.held_octet} >> shamt;
    sept0  = window[SEPTET_W-1:0];
    upper  = octet[OCTET_W-1:1];
    plus1  = {1'b0, st.emitted_count} + 9'd1;
    plus2  = {1'b0, st.emitted_count} + 9'd2;
    active = st.emitted_count < septet_count;
    room1  = plus1 < {1'b0, septet_count};

    st_next                  = st;
    push.n                   = 2'd0;
    push.item0.character     = GSM_TO_ASCII[sept0];
    push.item0.final_char    = plus1 == {1'b0, septet_count};
    push.item1.character     = GSM_TO_ASCII[upper];
    push.item1.final_char    = plus2 == {1'b0, septet_count};

    if (active) begin
      st_next.first_done = 1'b1;
      if (!st.first_done && pad_first) begin
        // fill bit in bit 0, first char from the upper seven bits
        push.n               = 2'd1;
        push.item0.character = GSM_TO_ASCII[upper];
      end else if (st.bit_phase == GROUP_LAST) begin
        push.n             = room1 ? 2'd2 : 2'd1;
        st_next.bit_phase  = '0;
        st_next.held_octet = '0;
      end else begin
        push.n             = 2'd1;
        st_next.bit_phase  = st.bit_phase + 3'd1;
        st_next.held_octet = octet;
      end
      st_next.emitted_count = st.emitted_count + COUNT_W'(push.n);
    end
  end

endmodule

@@ src/gsm7_outq.sv @@
`include "gsm7_septet_unpacker_core_macros.svh"

module gsm7_outq import gsm7_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  input  push_t        push,
  output logic         ready,
  gsm7_char_if.source  chars
);

  out_item_t             q [OUTQ_DEPTH];
  out_item_t             q_next [OUTQ_DEPTH];
  logic [OUTQ_CNT_W-1:0] count;
  logic [OUTQ_CNT_W-1:0] count_next;
  logic [OUTQ_CNT_W-1:0] base;
  logic [1:0]            push_n;
  logic                  pop;

  assign ready            = count <= 2'd1;
  assign pop              = chars.valid && chars.ready;
  assign push_n           = push_valid ? push.n : 2'd0;
  assign chars.valid      = count != '0;
  assign chars.character  = q[0].character;
  assign chars.final_char = q[0].final_char;

  always_comb begin
    base       = pop ? count - 2'd1 : count;
    count_next = base + push_n;
    q_next[0]  = pop ? q[1] : q[0];
    q_next[1]  = pop ? q[2] : q[1];
    q_next[2]  = q[2];
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      if (push_n != 2'd0 && base == OUTQ_CNT_W'(i)) begin
        q_next[i] = push.item0;
      end
      if (push_n == 2'd2 && base + 2'd1 == OUTQ_CNT_W'(i)) begin
        q_next[i] = push.item1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  `GSM7_ASSERT(a_count_bound, count <= OUTQ_CNT_W'(OUTQ_DEPTH), "queue over depth")
  `GSM7_ASSERT(a_count_track, 1'b1 |=> 3'(count) == 3'($past(count)) + 3'($past(push_n)) - 3'($past(pop)), "queue count mismatch")
  `GSM7_ASSERT(a_pair_stall, push_valid && push.n == 2'd2 |=> !ready, "no stall after two chars")

endmodule

@@ src/gsm7_septet_unpacker_core.sv @@
// GSM 7-bit unpacker: takes packed SMS user-data octets on octets, one item per cycle while ready
// is high, and returns translated ASCII characters on chars, the one numbered septet_count carrying
// final_char. A character is registered in the output queue when its octet is taken. Seven octets
// give eight characters: the octet that closes a group of seven gives two, and ready then drops
// while the three-entry output queue drains. Ready is high whenever that queue holds at most one
// character. With pad_first set, the first octet gives one character from its upper seven bits.
// Once septet_count characters are out, further octets are taken and dropped. Writing either
// register restarts the message.
`include "gsm7_septet_unpacker_core_macros.svh"

module gsm7_septet_unpacker_core import gsm7_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  gsm7_octet_if.sink   octets,
  gsm7_char_if.source  chars,
  gsm7_cfg_if.sink     cfg
);

  logic               pad_first;
  logic [COUNT_W-1:0] septet_count;
  unpk_state_t        st;
  unpk_state_t        st_next;
  push_t              push;
  logic               outq_ready;
  logic               octet_acc;
  logic               cfg_acc;

  assign cfg.ready    = 1'b1;
  assign cfg_acc      = cfg.valid && cfg.ready;
  assign octets.ready = outq_ready;
  assign octet_acc    = octets.valid && octets.ready;

  gsm7_unpack u_unpack (
    .octet        (octets.octet),
    .st           (st),
    .pad_first    (pad_first),
    .septet_count (septet_count),
    .st_next      (st_next),
    .push         (push)
  );

  gsm7_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (octet_acc),
    .push       (push),
    .ready      (outq_ready),
    .chars      (chars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_first    <= 1'b0;
      septet_count <= '0;
      st           <= STATE_RESET;
    end else if (cfg_acc) begin
      case (cfg.index)
        REG_PAD_FIRST:    pad_first    <= cfg.data[0];
        REG_SEPTET_COUNT: septet_count <= cfg.data;
        default: ;
      endcase
      st <= STATE_RESET;
    end else if (octet_acc) begin
      st <= st_next;
    end
  end

  `GSM7_ASSERT(a_count_limit, st.emitted_count <= septet_count, "emitted past septet_count")
  `GSM7_ASSERT(a_phase_range, st.bit_phase <= GROUP_LAST, "bit phase out of group")
  `GSM7_ASSERT_ALWAYS(a_cfg_restart, cfg_acc |=> st == STATE_RESET, "no restart on write")

endmodule
